@@ rtl/skwg_pkg.sv @@
package skwg_pkg;

   // Default fraction bits of the shift and weight formats
   localparam int SKWG_FRAC_BITS = 14;

   // Field widths
   localparam int DELTA_W  = 16;
   localparam int WEIGHT_W = 16;
   localparam int ORDER_W  = 2;
   localparam int TAPS_W   = 3;
   localparam int N_TAPS   = 5;
   localparam int N_LIN    = 3;

   // Interpolation order codes
   localparam logic [ORDER_W-1:0] ORDER_LINEAR = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_CUBIC  = 2'd3;

   // Tap counts reported with each result
   localparam logic [TAPS_W-1:0] TAPS_NONE   = 3'd0;
   localparam logic [TAPS_W-1:0] TAPS_LINEAR = 3'd3;
   localparam logic [TAPS_W-1:0] TAPS_CUBIC  = 3'd5;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // Stage advance enables handed to each tap lane
   typedef struct packed {
      logic s2;
      logic s3;
   } adv_type;

endpackage

@@ rtl/skwg_tap_lane.sv @@
module skwg_tap_lane #(
   parameter int FRAC_BITS = skwg_pkg::SKWG_FRAC_BITS
) (
   input  logic                     clock,
   input  skwg_pkg::adv_type        adv,
   input  logic [FRAC_BITS+1:0]     a_in,
   input  logic                     near_in,
   input  logic                     far_in,
   output logic signed [FRAC_BITS+5:0] weight
);
   import skwg_pkg::*;

   localparam int AW  = FRAC_BITS + 2;   // |x|, saturated at 2.0
   localparam int SQW = FRAC_BITS + 3;   // x^2 up to 4.0
   localparam int CUW = FRAC_BITS + 4;   // x^3 up to 8.0
   localparam int PW  = 2 * AW;
   localparam int QW  = SQW + AW;
   localparam int VW  = FRAC_BITS + 6;
   localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
   localparam logic [QW-1:0] HALF_Q = QW'(1) << (FRAC_BITS - 1);
   localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

   logic [PW-1:0]  sq_prod;
   logic [SQW-1:0] sq2_in;
   logic [SQW-1:0] sq2_ff;
   logic [AW-1:0]  a2_ff;
   logic           near2_ff;
   logic           far2_ff;

   logic [QW-1:0]  cu_prod;
   logic [CUW-1:0] cu3_in;
   logic [CUW-1:0] cu3_ff;
   logic [SQW-1:0] sq3_ff;
   logic [AW-1:0]  a3_ff;
   logic           near3_ff;
   logic           far3_ff;

   logic signed [VW-1:0] cu_s;
   logic signed [VW-1:0] sq_s;
   logic signed [VW-1:0] a_s;
   logic signed [VW-1:0] v_near;
   logic signed [VW-1:0] v_far;
   logic signed [VW-1:0] v_sel;

   // Square, rounded half up
   assign sq_prod = PW'(a_in) * PW'(a_in);
   assign sq2_in  = SQW'((sq_prod + HALF_P) >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         sq2_ff   <= sq2_in;
         a2_ff    <= a_in;
         near2_ff <= near_in;
         far2_ff  <= far_in;
      end
   end

   // Cube from the rounded square, rounded again
   assign cu_prod = QW'(sq2_ff) * QW'(a2_ff);
   assign cu3_in  = CUW'((cu_prod + HALF_Q) >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         cu3_ff   <= cu3_in;
         sq3_ff   <= sq2_ff;
         a3_ff    <= a2_ff;
         near3_ff <= near2_ff;
         far3_ff  <= far2_ff;
      end
   end

   // Kernel polynomial at twice scale, then halve rounding up
   assign cu_s   = VW'(cu3_ff);
   assign sq_s   = VW'(sq3_ff);
   assign a_s    = VW'(a3_ff);
   assign v_near = (cu_s <<< 1) + cu_s - ((sq_s <<< 2) + sq_s) + (ONE_V <<< 1);
   assign v_far  = (sq_s <<< 2) + sq_s - cu_s - (a_s <<< 3) + (ONE_V <<< 2);
   assign v_sel  = near3_ff ? v_near : v_far;
   assign weight = far3_ff ? '0 : ((v_sel + VW'(1)) >>> 1);

endmodule

@@ rtl/shift_kernel_weight_generator_top.sv @@
// Four register stages (clamp, square, cube, result) lie between the input transfer and rsp_valid.
// Throughput: one item per cycle while rsp_stall is low; the two multipliers of each tap lane
// (square, then cube) each sit in a registered stage of their own.
// Stalls ripple back through valid bits, so empty stages still fill.
// Reset (synchronous, active high) empties the pipeline and sets the
// interpolation order to linear.
module shift_kernel_weight_generator_top #(
   parameter int FRAC_BITS = skwg_pkg::SKWG_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [skwg_pkg::DELTA_W-1:0]   req_shift_delta,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_0,
   output logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_1,
   output logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_2,
   output logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_3,
   output logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_4,
   output logic [skwg_pkg::TAPS_W-1:0]           rsp_tap_count,
   output logic                                  rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [skwg_pkg::ORDER_W-1:0]          csr_interp_order
);
   import skwg_pkg::*;

   localparam int AW = FRAC_BITS + 2;
   localparam int XW = (FRAC_BITS + 4 > DELTA_W + 1) ? FRAC_BITS + 4 : DELTA_W + 1;
   localparam int VW = FRAC_BITS + 6;
   localparam int LW = FRAC_BITS + 1;
   localparam logic signed [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
   localparam logic signed [XW-1:0] TWO_X = XW'(1) << (FRAC_BITS + 1);
   localparam logic signed [XW-1:0] LIN_OFF [N_LIN]  = '{-ONE_X, '0, ONE_X};
   localparam logic signed [XW-1:0] CUB_OFF [N_TAPS] = '{-TWO_X, -ONE_X, '0, ONE_X, TWO_X};

   // Configuration register
   logic [ORDER_W-1:0] order_ff;
   logic [ORDER_W-1:0] order_in;

   // Handshake chain
   logic rdy1, rdy2, rdy3, rdy4;
   adv_type adv;

   // Stage 1: clamp, tap positions, linear weights
   logic signed [XW-1:0] delta_ext;
   logic signed [XW-1:0] delta_c;
   logic signed [XW-1:0] xl;
   logic signed [XW-1:0] axl;
   logic signed [XW-1:0] tl;
   logic signed [XW-1:0] xc;
   logic signed [XW-1:0] axc;
   logic [LW-1:0]  lin1_in  [N_LIN];
   logic [AW-1:0]  a1_in    [N_TAPS];
   logic           near1_in [N_TAPS];
   logic           far1_in  [N_TAPS];
   logic           valid1_in, valid1_ff;
   logic [ORDER_W-1:0] mode1_ff;
   logic [LW-1:0]  lin1_ff  [N_LIN];
   logic [AW-1:0]  a1_ff    [N_TAPS];
   logic           near1_ff [N_TAPS];
   logic           far1_ff  [N_TAPS];

   // Stages 2 and 3: side band alongside the tap lanes
   logic               valid2_in, valid2_ff;
   logic               valid3_in, valid3_ff;
   logic [ORDER_W-1:0] mode2_ff, mode3_ff;
   logic [LW-1:0]      lin2_ff [N_LIN];
   logic [LW-1:0]      lin3_ff [N_LIN];
   logic signed [VW-1:0] cub_w [N_TAPS];

   // Stage 4: result register
   logic                       valid4_in, valid4_ff;
   logic signed [WEIGHT_W-1:0] weight4_in [N_TAPS];
   logic signed [WEIGHT_W-1:0] weight4_ff [N_TAPS];
   logic [TAPS_W-1:0]          taps4_in, taps4_ff;
   logic                       status4_in, status4_ff;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;
   assign order_in  = csr_valid ? csr_interp_order : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_LINEAR;
      end else begin
         order_ff <= order_in;
      end
   end

   // A stage takes new data when it is empty or its successor moves on
   assign rdy4      = !valid4_ff || !rsp_stall;
   assign rdy3      = !valid3_ff || rdy4;
   assign rdy2      = !valid2_ff || rdy3;
   assign rdy1      = !valid1_ff || rdy2;
   assign req_stall = !rdy1;
   assign adv.s2    = rdy2;
   assign adv.s3    = rdy3;

   assign valid1_in = rdy1 ? req_valid : valid1_ff;
   assign valid2_in = rdy2 ? valid1_ff : valid2_ff;
   assign valid3_in = rdy3 ? valid2_ff : valid3_ff;
   assign valid4_in = rdy4 ? valid3_ff : valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
         valid4_ff <= valid4_in;
      end
   end

   // Clamp the shift to [-1, 1]
   always_comb begin
      delta_ext = XW'(req_shift_delta);
      if (delta_ext > ONE_X) begin
         delta_c = ONE_X;
      end else if (delta_ext < -ONE_X) begin
         delta_c = -ONE_X;
      end else begin
         delta_c = delta_ext;
      end
   end

   // Tent weights
   always_comb begin
      xl  = '0;
      axl = '0;
      tl  = '0;
      for (int k = 0; k < N_LIN; k++) begin
         xl  = delta_c + LIN_OFF[k];
         axl = xl[XW-1] ? -xl : xl;
         tl  = ONE_X - axl;
         lin1_in[k] = (tl > 0) ? LW'(tl) : '0;
      end
   end

   // Cubic tap distances, saturated at 2.0 with a far flag
   always_comb begin
      xc  = '0;
      axc = '0;
      for (int k = 0; k < N_TAPS; k++) begin
         xc  = delta_c + CUB_OFF[k];
         axc = xc[XW-1] ? -xc : xc;
         far1_in[k]  = axc > TWO_X;
         near1_in[k] = axc <= ONE_X;
         a1_in[k]    = far1_in[k] ? AW'(TWO_X) : AW'(axc);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mode1_ff <= order_ff;
         lin1_ff  <= lin1_in;
         a1_ff    <= a1_in;
         near1_ff <= near1_in;
         far1_ff  <= far1_in;
      end
   end

   // Side band follows the lanes
   always_ff @(posedge clock) begin
      if (rdy2) begin
         mode2_ff <= mode1_ff;
         lin2_ff  <= lin1_ff;
      end
      if (rdy3) begin
         mode3_ff <= mode2_ff;
         lin3_ff  <= lin2_ff;
      end
   end

   // One square/cube lane per cubic tap
   for (genvar g = 0; g < N_TAPS; g++) begin : g_lane
      skwg_tap_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .adv     (adv),
         .a_in    (a1_ff[g]),
         .near_in (near1_ff[g]),
         .far_in  (far1_ff[g]),
         .weight  (cub_w[g])
      );
   end

   // Select the result by mode
   always_comb begin
      for (int k = 0; k < N_TAPS; k++) begin
         weight4_in[k] = '0;
      end
      taps4_in   = TAPS_NONE;
      status4_in = STATUS_ERROR;
      case (mode3_ff)
         ORDER_LINEAR: begin
            for (int k = 0; k < N_LIN; k++) begin
               weight4_in[k] = WEIGHT_W'(VW'(lin3_ff[k]));
            end
            taps4_in   = TAPS_LINEAR;
            status4_in = STATUS_OK;
         end
         ORDER_CUBIC: begin
            for (int k = 0; k < N_TAPS; k++) begin
               weight4_in[k] = WEIGHT_W'(cub_w[k]);
            end
            taps4_in   = TAPS_CUBIC;
            status4_in = STATUS_OK;
         end
         default: begin
            taps4_in   = TAPS_NONE;
            status4_in = STATUS_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         weight4_ff <= weight4_in;
         taps4_ff   <= taps4_in;
         status4_ff <= status4_in;
      end
   end

   assign rsp_valid     = valid4_ff;
   assign rsp_weight_0  = weight4_ff[0];
   assign rsp_weight_1  = weight4_ff[1];
   assign rsp_weight_2  = weight4_ff[2];
   assign rsp_weight_3  = weight4_ff[3];
   assign rsp_weight_4  = weight4_ff[4];
   assign rsp_tap_count = taps4_ff;
   assign rsp_status    = status4_ff;

endmodule

@@ rtl/skwg_checker.sv @@
module skwg_port_props (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_0,
   input logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_1,
   input logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_2,
   input logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_3,
   input logic signed [skwg_pkg::WEIGHT_W-1:0]  rsp_weight_4,
   input logic [skwg_pkg::TAPS_W-1:0]           rsp_tap_count,
   input logic                                  rsp_status
);
   import skwg_pkg::*;

   // Pipeline is empty the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight_0) &&
      $stable(rsp_weight_1) && $stable(rsp_weight_2) && $stable(rsp_weight_3) &&
      $stable(rsp_weight_4) && $stable(rsp_tap_count) && $stable(rsp_status))
      else $error("stalled result changed");

   // Error results carry no taps
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ERROR |-> rsp_tap_count == TAPS_NONE &&
      rsp_weight_0 == 0 && rsp_weight_1 == 0 && rsp_weight_2 == 0 &&
      rsp_weight_3 == 0 && rsp_weight_4 == 0)
      else $error("error result with taps");

   // Good results are linear or cubic
   a_ok_taps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
      rsp_tap_count == TAPS_LINEAR || rsp_tap_count == TAPS_CUBIC)
      else $error("bad tap count");

   // Linear results leave the outer taps empty
   a_lin_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tap_count == TAPS_LINEAR |-> rsp_weight_3 == 0 && rsp_weight_4 == 0)
      else $error("linear result with outer taps");

endmodule

bind shift_kernel_weight_generator_top skwg_port_props u_skwg_port_props (.*);
